>>> design/http_request_framer_macros.svh
`ifndef HTTP_REQUEST_FRAMER_MACROS_SVH
`define HTTP_REQUEST_FRAMER_MACROS_SVH

// Checked on every clock edge outside reset.
`define HRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HRF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/hrf_pkg.sv
package hrf_pkg;

	localparam int LENGTH_BITS   = 32;
	localparam int OUT_BITS      = 32;
	localparam int WINDOW_BITS   = 16;
	localparam int NAME_LEN      = 14;
	localparam int NAME_IDX_BITS = 4;

	typedef logic [LENGTH_BITS-1:0] len_t;
	typedef logic [OUT_BITS-1:0]    out_t;
	typedef logic [WINDOW_BITS-1:0] window_t;
	typedef logic [NAME_IDX_BITS-1:0] name_idx_t;

	localparam window_t WINDOW_RESET = 16'd1024;

	typedef enum logic [1:0] {
		OP_ACCEPT = 2'd0,
		OP_DATA   = 2'd1,
		OP_CLOSE  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_SKIP   = 3'd1,
		PH_SPACE  = 3'd2,
		PH_DIGITS = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [23:0] CRLFCR  = {CH_CR, CH_LF, CH_CR};

	// "Content-Length"
	function automatic logic [7:0] name_char(input name_idx_t idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h43;
			4'd1:    c = 8'h6F;
			4'd2:    c = 8'h6E;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2D;
			4'd8:    c = 8'h4C;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6E;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic len_t sat_inc(input len_t v);
		return (&v) ? v : len_t'(v + 1'b1);
	endfunction

	// v * 10 + d, saturating at all ones
	function automatic len_t mul10_add(input len_t v, input logic [3:0] d);
		logic [LENGTH_BITS+3:0] w;
		logic [LENGTH_BITS+3:0] p;
		w = {4'b0, v};
		p = (w << 3) + (w << 1) + (LENGTH_BITS+4)'(d);
		return (p[LENGTH_BITS+3:LENGTH_BITS] != '0) ? '1 : p[LENGTH_BITS-1:0];
	endfunction

	function automatic out_t to_out(input len_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_BITS-1:0];
	endfunction

endpackage

>>> design/http_request_framer.sv
// HTTP request framer, one request per connection, one byte per transaction.
// An accept transaction starts a connection, data transactions carry the stream,
// a close transaction ends it; every input transaction gives exactly one result.
// The first CRLFCRLF ends the header; the first "Content-Length" name ending
// within header_window bytes of the stream start supplies the body length
// (0 when absent, saturating). message_ready rises on a chunk's last byte once
// the body count reaches that length. Throughput is one transaction per clock
// while out_stall is low; each passes an input register, then a result register;
// the critical path is the state update, chiefly the decimal accumulator's
// times-ten add and saturation. header_window may only be written while no
// transaction is in flight.
module http_request_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  hrf_pkg::window_t  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [7:0]        data_byte,
	input  logic              chunk_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              message_ready,
	output logic              closed,
	output logic              headers_done,
	output hrf_pkg::out_t     header_length,
	output hrf_pkg::out_t     content_length,
	output hrf_pkg::out_t     body_count
);
	import hrf_pkg::*;

	window_t   window_q;

	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       active_q,   active_n;
	logic [23:0] recent_q,  recent_n;
	len_t       bytes_q,    bytes_n;
	name_idx_t  prog_q,     prog_n;
	phase_t     phase_q,    phase_n;
	len_t       length_q,   length_n;
	logic       hdr_done_q, hdr_done_n;
	len_t       hdr_bytes_q, hdr_bytes_n;
	len_t       body_q,     body_n;

	logic       ready_c, closed_c, done_c;
	out_t       hlen_c, clen_c, body_c;

	logic       out_valid_q;
	logic       ready_s2, closed_s2, done_s2;
	out_t       hlen_s2, clen_s2, body_s2;

	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			byte_s1   <= data_byte;
			last_s1   <= chunk_last;
		end
	end

	always_comb begin
		logic [7:0] b;
		name_idx_t  prog;
		logic       is_digit;

		b        = byte_s1;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		prog     = prog_q;

		active_n    = active_q;
		recent_n    = recent_q;
		bytes_n     = bytes_q;
		prog_n      = prog_q;
		phase_n     = phase_q;
		length_n    = length_q;
		hdr_done_n  = hdr_done_q;
		hdr_bytes_n = hdr_bytes_q;
		body_n      = body_q;
		ready_c     = 1'b0;
		closed_c    = 1'b0;

		unique case (opcode_s1)
			OP_ACCEPT: begin
				active_n    = 1'b1;
				recent_n    = '0;
				bytes_n     = '0;
				prog_n      = '0;
				phase_n     = PH_SEARCH;
				length_n    = '0;
				hdr_done_n  = 1'b0;
				hdr_bytes_n = '0;
				body_n      = '0;
			end
			OP_DATA: begin
				if (active_q) begin
					bytes_n = sat_inc(bytes_q);
					if (hdr_done_q) begin
						body_n = sat_inc(body_q);
					end else begin
						unique case (phase_q)
							PH_SEARCH: begin
								if (b == name_char(prog_q)) begin
									prog = name_idx_t'(prog_q + 1'b1);
								end else begin
									prog = (b == CH_C) ? name_idx_t'(1) : '0;
								end
								if (prog == name_idx_t'(NAME_LEN)) begin
									prog = '0;
									if (64'(bytes_n) <= 64'(window_q)) begin
										phase_n = PH_SKIP;
									end
								end
								prog_n = prog;
							end
							PH_SKIP: begin
								phase_n = PH_SPACE;
							end
							PH_SPACE, PH_DIGITS: begin
								// one optional space, then digits until a non-digit
								if (phase_q == PH_SPACE && b == CH_SPACE) begin
									phase_n = PH_DIGITS;
								end else if (is_digit) begin
									phase_n  = PH_DIGITS;
									length_n = mul10_add(length_q, b[3:0]);
								end else begin
									phase_n = PH_DONE;
								end
							end
							PH_DONE: begin
							end
							default: begin
							end
						endcase
						if (b == CH_LF && recent_q == CRLFCR) begin
							hdr_done_n  = 1'b1;
							hdr_bytes_n = bytes_n;
						end
					end
					recent_n = {recent_q[15:0], b};
					ready_c  = last_s1 && hdr_done_n && (body_n >= length_n);
				end
			end
			OP_CLOSE: begin
				closed_c = active_q;
			end
			default: begin
			end
		endcase

		done_c = active_n && hdr_done_n;
		hlen_c = active_n ? to_out(hdr_bytes_n) : '0;
		clen_c = active_n ? to_out(length_n) : '0;
		body_c = active_n ? to_out(body_n) : '0;

		// close reports the state as it stood, then drops the connection
		if (closed_c) begin
			active_n    = 1'b0;
			recent_n    = '0;
			bytes_n     = '0;
			prog_n      = '0;
			phase_n     = PH_SEARCH;
			length_n    = '0;
			hdr_done_n  = 1'b0;
			hdr_bytes_n = '0;
			body_n      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			recent_q    <= '0;
			bytes_q     <= '0;
			prog_q      <= '0;
			phase_q     <= PH_SEARCH;
			length_q    <= '0;
			hdr_done_q  <= 1'b0;
			hdr_bytes_q <= '0;
			body_q      <= '0;
		end else if (advance) begin
			active_q    <= active_n;
			recent_q    <= recent_n;
			bytes_q     <= bytes_n;
			prog_q      <= prog_n;
			phase_q     <= phase_n;
			length_q    <= length_n;
			hdr_done_q  <= hdr_done_n;
			hdr_bytes_q <= hdr_bytes_n;
			body_q      <= body_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ready_s2  <= ready_c;
			closed_s2 <= closed_c;
			done_s2   <= done_c;
			hlen_s2   <= hlen_c;
			clen_s2   <= clen_c;
			body_s2   <= body_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign message_ready  = ready_s2;
	assign closed         = closed_s2;
	assign headers_done   = done_s2;
	assign header_length  = hlen_s2;
	assign content_length = clen_s2;
	assign body_count     = body_s2;

`include "http_request_framer_macros.svh"

	`HRF_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!out_valid_q && !valid_s1), "pipeline not empty in reset")
	`HRF_ASSERT(a_stall_only_busy, in_stall |-> (valid_s1 && out_valid_q), "input stalled with room")
	`HRF_ASSERT(a_prog_range, prog_q < name_idx_t'(NAME_LEN), "name match index out of range")
	`HRF_ASSERT(a_ready_needs_hdr, out_valid_q |-> (!ready_s2 || (done_s2 && !closed_s2)), "ready without header or on close")
	`HRF_ASSERT(a_body_after_hdr, (body_q != '0) |-> hdr_done_q, "body counted before header end")

endmodule

>>> sim/http_request_framer_tb.sv
module http_request_framer_tb;
	import hrf_pkg::*;

	localparam logic [1:0] OP_UNKNOWN     = 2'd3;
	localparam string      LEN_NAME       = "Content-Length";
	localparam int         ITEMS_PER_PHASE = 190;
	localparam int         NUM_PHASES     = 6;
	localparam int         NUM_DIRECTED   = 23;

	typedef struct packed {
		logic ready;
		logic closed;
		logic hdone;
		out_t hlen;
		out_t clen;
		out_t bcount;
	} frame_result_t;

	typedef struct packed {
		logic [1:0]    op;
		logic [7:0]    data;
		logic          last;
		logic          pinned;
		frame_result_t pinned_res;
	} req_item_t;

	localparam frame_result_t IDLE_RES   = '0;
	localparam frame_result_t CLOSED_RES = '{1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0};
	localparam frame_result_t HDR5_RES   = '{1'b1, 1'b0, 1'b1, 32'd5, 32'd0, 32'd0};

	// short directed opener; rows with pinned = 0 are checked against the predictor
	localparam req_item_t DIRECTED [NUM_DIRECTED] = '{
		'{OP_DATA,    8'h41,    1'b1, 1'b1, IDLE_RES},   // data while inactive
		'{OP_CLOSE,   8'hFF,    1'b1, 1'b1, IDLE_RES},   // close while inactive
		'{OP_UNKNOWN, 8'h00,    1'b0, 1'b1, IDLE_RES},
		'{OP_ACCEPT,  8'hFF,    1'b1, 1'b1, IDLE_RES},   // chunk_last ignored
		'{OP_DATA,    8'hFF,    1'b1, 1'b0, IDLE_RES},
		'{OP_UNKNOWN, CH_CR,    1'b1, 1'b0, IDLE_RES},
		'{OP_DATA,    CH_CR,    1'b0, 1'b0, IDLE_RES},
		'{OP_DATA,    CH_LF,    1'b0, 1'b0, IDLE_RES},
		'{OP_DATA,    CH_CR,    1'b0, 1'b0, IDLE_RES},
		'{OP_DATA,    CH_LF,    1'b1, 1'b1, HDR5_RES},
		'{OP_DATA,    8'h00,    1'b1, 1'b0, IDLE_RES},
		'{OP_DATA,    8'hFF,    1'b0, 1'b0, IDLE_RES},
		'{OP_CLOSE,   8'h00,    1'b1, 1'b0, IDLE_RES},
		'{OP_CLOSE,   8'hFF,    1'b0, 1'b1, IDLE_RES},
		'{OP_ACCEPT,  8'h00,    1'b0, 1'b1, IDLE_RES},
		'{OP_ACCEPT,  8'hFF,    1'b1, 1'b1, IDLE_RES},   // accept while active
		'{OP_DATA,    CH_CR,    1'b0, 1'b0, IDLE_RES},
		'{OP_DATA,    CH_LF,    1'b0, 1'b0, IDLE_RES},
		'{OP_DATA,    CH_CR,    1'b0, 1'b0, IDLE_RES},
		'{OP_DATA,    CH_LF,    1'b0, 1'b0, IDLE_RES},
		'{OP_DATA,    8'h80,    1'b1, 1'b0, IDLE_RES},
		'{OP_ACCEPT,  8'h55,    1'b1, 1'b1, IDLE_RES},
		'{OP_CLOSE,   8'hAA,    1'b1, 1'b1, CLOSED_RES}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we = 1'b0;
	window_t    cfg_wdata = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] opcode = OP_ACCEPT;
	logic [7:0] data_byte = '0;
	logic       chunk_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       message_ready;
	logic       closed;
	logic       headers_done;
	out_t       header_length;
	out_t       content_length;
	out_t       body_count;

	logic          cur_pinned = 1'b0;
	frame_result_t cur_pinned_res = '0;

	req_item_t     stim_q[$];
	frame_result_t framing_q[$];
	int            error_count = 0;

	// framer model state
	window_t   window_reg = WINDOW_RESET;
	logic      conn_active = 1'b0;
	logic [23:0] tail_bytes = '0;
	len_t      seen_count = '0;
	name_idx_t name_pos = '0;
	phase_t    len_phase = PH_SEARCH;
	len_t      len_value = '0;
	logic      hdr_done = 1'b0;
	len_t      hdr_len = '0;
	len_t      body_len = '0;

	int stall_mode = 0;
	int stall_left = 0;

	http_request_framer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.data_byte      (data_byte),
		.chunk_last     (chunk_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.message_ready  (message_ready),
		.closed         (closed),
		.headers_done   (headers_done),
		.header_length  (header_length),
		.content_length (content_length),
		.body_count     (body_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic len_t sat_bump(input len_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic out_t clip_out(input len_t v);
		return (64'(v) > 64'hFFFF_FFFF) ? '1 : out_t'(v);
	endfunction

	task automatic clear_conn();
		conn_active = 1'b0;
		tail_bytes  = '0;
		seen_count  = '0;
		name_pos    = '0;
		len_phase   = PH_SEARCH;
		len_value   = '0;
		hdr_done    = 1'b0;
		hdr_len     = '0;
		body_len    = '0;
	endtask

	// one transaction through the framer model
	task automatic predict_framing(input logic [1:0] op, input logic [7:0] b,
			input logic last, output frame_result_t r);
		logic rdy;
		logic cls;
		logic was_done;
		logic space_eaten;
		name_idx_t p;
		logic [3:0] digit;
		logic [LENGTH_BITS+3:0] wide;
		rdy = 1'b0;
		cls = 1'b0;
		case (op)
			OP_ACCEPT: begin
				clear_conn();
				conn_active = 1'b1;
			end
			OP_DATA: begin
				if (conn_active) begin
					was_done = hdr_done;
					seen_count = sat_bump(seen_count);
					if (was_done) begin
						body_len = sat_bump(body_len);
					end else begin
						if (len_phase == PH_SEARCH) begin
							p = name_pos;
							if (b == LEN_NAME[p])
								p = p + 1'b1;
							else
								p = (b == CH_C) ? 4'd1 : 4'd0;
							if (p == NAME_LEN) begin
								p = '0;
								if (seen_count <= len_t'(window_reg))
									len_phase = PH_SKIP;
							end
							name_pos = p;
						end else if (len_phase == PH_SKIP) begin
							len_phase = PH_SPACE;
						end else if (len_phase != PH_DONE) begin
							space_eaten = 1'b0;
							if (len_phase == PH_SPACE) begin
								len_phase = PH_DIGITS;
								space_eaten = (b == CH_SPACE);
							end
							if (!space_eaten) begin
								if (b >= CH_ZERO && b <= CH_NINE) begin
									digit = 4'(b - CH_ZERO);
									wide = (LENGTH_BITS+4)'(len_value) * 10 + digit;
									if (wide > (LENGTH_BITS+4)'({LENGTH_BITS{1'b1}}))
										len_value = '1;
									else
										len_value = len_t'(wide);
								end else begin
									len_phase = PH_DONE;
								end
							end
						end
						if (b == CH_LF && tail_bytes == CRLFCR) begin
							hdr_done = 1'b1;
							hdr_len = seen_count;
						end
					end
					tail_bytes = {tail_bytes[15:0], b};
					rdy = last && hdr_done && (body_len >= len_value);
				end
			end
			OP_CLOSE: begin
				cls = conn_active;
			end
			default: ;
		endcase
		if (conn_active)
			r = '{rdy, cls, hdr_done, clip_out(hdr_len), clip_out(len_value),
				clip_out(body_len)};
		else
			r = '0;
		if (cls)
			clear_conn();
	endtask

	task automatic check_field(input string field_name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			error_count++;
			$display("%0t mismatch %s: expected %0h, got %0h", $time, field_name, exp_v,
				act_v);
		end
	endtask

	always @(posedge clk) begin : result_monitor
		frame_result_t want;
		frame_result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_framing(opcode, data_byte, chunk_last, want);
				if (cur_pinned)
					want = cur_pinned_res;
				framing_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = '{message_ready, closed, headers_done, header_length, content_length,
					body_count};
				if (framing_q.size() == 0) begin
					error_count++;
					$display("%0t unexpected result transaction: expected none, got %0h",
						$time, got);
				end else begin
					want = framing_q.pop_front();
					check_field("message_ready", 32'(want.ready), 32'(got.ready));
					check_field("closed", 32'(want.closed), 32'(got.closed));
					check_field("headers_done", 32'(want.hdone), 32'(got.hdone));
					check_field("header_length", want.hlen, got.hlen);
					check_field("content_length", want.clen, got.clen);
					check_field("body_count", want.bcount, got.bcount);
				end
			end
		end
	end

	// receiver backpressure: a random stall mode is chosen for each random-length run
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(64, 400);
			stall_mode = $urandom_range(0, 3);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 30);
			2: out_stall <= ((stall_left % 5) < 2);
			default: out_stall <= ($urandom_range(0, 99) < 80);
		endcase
	end

	task automatic push_item(input logic [1:0] op, input logic [7:0] b, input logic last);
		req_item_t it;
		it = '0;
		it.op = op;
		it.data = b;
		it.last = last;
		stim_q.push_back(it);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_item(OP_DATA, s[i], $urandom_range(0, 9) == 0);
	endtask

	function automatic string filler_line();
		string s;
		s = "X-";
		repeat ($urandom_range(0, 20))
			s = {s, $sformatf("%c", 8'($urandom_range(8'h21, 8'h7E)))};
		return {s, "\r\n"};
	endfunction

	// one connection: mostly well-formed requests with random content, some broken
	task automatic queue_request();
		string head;
		string digits;
		int val;
		int kind;
		int nbody;
		logic long_value;
		head = "";
		digits = "";
		long_value = 1'b0;
		val = $urandom_range(0, 40);
		push_item(OP_ACCEPT, 8'($urandom), 1'($urandom));
		if ($urandom_range(0, 3) != 0)
			head = "GET / HTTP/1.1\r\n";
		repeat ($urandom_range(0, 2))
			head = {head, filler_line()};
		kind = $urandom_range(0, 9);
		case (kind)
			0: ;
			1: head = {head, "content-length: 12\r\n"};
			2: head = {head, "Content-LenContent-Length"};
			3: head = {head, "CContent-Length"};
			default: head = {head, LEN_NAME};
		endcase
		if (kind >= 2) begin
			if ($urandom_range(0, 7) == 0)
				head = {head, $sformatf("%c", 8'($urandom_range(8'h20, 8'h7E)))};
			else
				head = {head, ":"};
			case ($urandom_range(0, 5))
				0: ;
				1: head = {head, "  "};
				default: head = {head, " "};
			endcase
			case ($urandom_range(0, 9))
				0: begin
					long_value = 1'b1;
					repeat ($urandom_range(10, 12))
						digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
				end
				1: digits = $sformatf("00%0d", val);
				2: digits = "";
				default: digits = $sformatf("%0d", val);
			endcase
			head = {head, digits, "\r\n"};
			// a second length header must not override the first
			if ($urandom_range(0, 4) == 0)
				head = {head, "Content-Length: 3\r\n"};
		end
		repeat ($urandom_range(0, 1))
			head = {head, filler_line()};
		case ($urandom_range(0, 9))
			0: head = {head, "\n\r\n"};
			1: ;
			default: head = {head, "\r\n"};
		endcase
		push_text(head);

		if (long_value)
			nbody = $urandom_range(0, 20);
		else
			nbody = val + $urandom_range(0, 6) - 3;
		if (nbody < 0)
			nbody = 0;
		if ($urandom_range(0, 5) == 0)
			push_text("Content-Length: 7");
		for (int i = 0; i < nbody; i++)
			push_item(OP_DATA, 8'($urandom),
				(i == nbody - 1) ? 1'($urandom) : ($urandom_range(0, 7) == 0));

		if ($urandom_range(0, 4) != 0)
			push_item(OP_CLOSE, 8'($urandom), 1'($urandom));
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3))
				push_item(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 6))
				push_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
	endtask

	// sender: bursts with random gaps, sometimes holding off until the block drains
	task automatic feed_stream();
		req_item_t it;
		int burst_left;
		int gap;
		logic drain;
		burst_left = 0;
		while (stim_q.size() > 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				drain = ($urandom_range(0, 24) == 0);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (drain && gap == 0)
					gap = 1;
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
					while (drain && framing_q.size() > 0)
						@(posedge clk);
				end
			end
			burst_left--;
			it = stim_q.pop_front();
			in_valid       <= 1'b1;
			opcode         <= it.op;
			data_byte      <= it.data;
			chunk_last     <= it.last;
			cur_pinned     <= it.pinned;
			cur_pinned_res <= it.pinned_res;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
		end
		in_valid <= 1'b0;
	endtask

	task automatic settle();
		while (framing_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input window_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		window_reg = v;
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		// a real falling edge so the asynchronous reset takes hold at time zero
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			stim_q.push_back(DIRECTED[i]);
		feed_stream();

		// first phase runs on the reset window
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				settle();
				case (ph)
					1: write_window(window_t'(NAME_LEN));
					2: write_window('1);
					3: write_window(16'd30);
					4: write_window(window_t'($urandom_range(14, 60)));
					default: write_window(window_t'($urandom_range(14, 65535)));
				endcase
			end
			while (stim_q.size() < ITEMS_PER_PHASE)
				queue_request();
			feed_stream();
		end

		settle();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/hrf_pkg.sv
design/http_request_framer.sv
sim/http_request_framer_tb.sv
